// ===== src/cdoc_pkg.sv =====
// shared types, constants and calendar tables for the date converter
package cdoc_pkg;

	// decimal packing divisors
	localparam logic [13:0] DIV_CAL = 14'd10000;
	localparam logic [13:0] DIV_ORD = 14'd1000;

	// reciprocals floor(2^41 / d); quotient estimate is low by at most one
	localparam int unsigned RECIP_SHIFT = 41;
	localparam logic [31:0] RECIP_CAL = 32'd219902325;
	localparam logic [31:0] RECIP_ORD = 32'd2199023255;

	// exact reciprocals for divide by 100 on narrow values
	localparam logic [12:0] RECIP_100_REM = 13'd5243;    // shift 19, rem < 10000
	localparam logic [17:0] RECIP_100_YEAR = 18'd167773; // shift 24, year < 199728

	localparam logic [13:0] MAX_CAL_YEAR = 14'd9999;

	// mode codes
	localparam logic MODE_CAL_TO_ORD = 1'b0;
	localparam logic MODE_ORD_TO_CAL = 1'b1;

	// word after the integer divide
	typedef struct packed {
		logic        valid;
		logic        mode;
		logic [17:0] year;
		logic [13:0] rem;
	} div_word_t;

	// word after digit split and leap decision
	typedef struct packed {
		logic        valid;
		logic        mode;
		logic [17:0] year;
		logic [13:0] rem;
		logic [6:0]  mon;
		logic [6:0]  day;
		logic        leap;
	} fld_word_t;

	// month length, month 1..12
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] n;
		case (mon)
			4'd1: n = 5'd31;
			4'd2: n = leap ? 5'd29 : 5'd28;
			4'd3: n = 5'd31;
			4'd4: n = 5'd30;
			4'd5: n = 5'd31;
			4'd6: n = 5'd30;
			4'd7: n = 5'd31;
			4'd8: n = 5'd31;
			4'd9: n = 5'd30;
			4'd10: n = 5'd31;
			4'd11: n = 5'd30;
			4'd12: n = 5'd31;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	// days before the first of month 1..12
	function automatic logic [8:0] days_before(input logic [3:0] mon, input logic leap);
		logic [8:0] n;
		case (mon)
			4'd1: n = 9'd0;
			4'd2: n = 9'd31;
			4'd3: n = 9'd59;
			4'd4: n = 9'd90;
			4'd5: n = 9'd120;
			4'd6: n = 9'd151;
			4'd7: n = 9'd181;
			4'd8: n = 9'd212;
			4'd9: n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			4'd12: n = 9'd334;
			default: n = 9'd0;
		endcase
		if (mon > 4'd2 && leap) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

endpackage

// ===== src/cdoc_divide.sv =====
// stages 1-2: split the packed value into year and remainder
module cdoc_divide (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic                  mode,
	input  logic [26:0]           date_value,
	output cdoc_pkg::div_word_t   word_out
);

	logic        valid_s1;
	logic        mode_s1;
	logic [26:0] x_s1;
	logic [17:0] qest_s1;

	logic        valid_s2;
	logic        mode_s2;
	logic [17:0] year_s2;
	logic [13:0] rem_s2;

	logic [31:0] recip;
	logic [58:0] prod;
	logic [13:0] divisor;
	logic [31:0] qd;
	logic [31:0] r_full;
	logic [14:0] r;
	logic [17:0] year_c;
	logic [13:0] rem_c;

	// stage 1: reciprocal multiply for the quotient estimate
	always_comb begin
		recip = (mode == cdoc_pkg::MODE_CAL_TO_ORD) ? cdoc_pkg::RECIP_CAL
			: cdoc_pkg::RECIP_ORD;
		prod = 59'(date_value) * 59'(recip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			x_s1    <= date_value;
			qest_s1 <= prod[58:cdoc_pkg::RECIP_SHIFT];
		end
	end

	// stage 2: remainder and one-step correction
	always_comb begin
		divisor = (mode_s1 == cdoc_pkg::MODE_CAL_TO_ORD) ? cdoc_pkg::DIV_CAL
			: cdoc_pkg::DIV_ORD;
		qd = 32'(qest_s1) * 32'(divisor);
		r_full = 32'(x_s1) - qd;
		r = r_full[14:0];
		if (r >= 15'(divisor)) begin
			year_c = qest_s1 + 18'd1;
			rem_c  = 14'(r - 15'(divisor));
		end else begin
			year_c = qest_s1;
			rem_c  = r[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			year_s2 <= year_c;
			rem_s2  <= rem_c;
		end
	end

	// stage 2 word to the next unit
	assign word_out = {valid_s2, mode_s2, year_s2, rem_s2};

endmodule

// ===== src/cdoc_field.sv =====
// stages 3-4: month and day digits, leap year decision
module cdoc_field (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  cdoc_pkg::div_word_t   word_in,
	output cdoc_pkg::fld_word_t   word_out
);

	logic        valid_s3;
	logic        mode_s3;
	logic [17:0] year_s3;
	logic [13:0] rem_s3;
	logic [6:0]  mon_s3;
	logic [10:0] q100_s3;

	logic        valid_s4;
	logic        mode_s4;
	logic [17:0] year_s4;
	logic [13:0] rem_s4;
	logic [6:0]  mon_s4;
	logic [6:0]  day_s4;
	logic        leap_s4;

	logic [26:0] mon_prod;
	logic [35:0] q100_prod;
	logic [13:0] mon100;
	logic [17:0] q100x100;
	logic [13:0] day_full;
	logic        div100;
	logic        leap_c;

	// stage 3: divide by 100 through exact reciprocals
	always_comb begin
		mon_prod  = 27'(word_in.rem) * 27'(cdoc_pkg::RECIP_100_REM);
		q100_prod = 36'(word_in.year) * 36'(cdoc_pkg::RECIP_100_YEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= word_in.mode;
			year_s3 <= word_in.year;
			rem_s3  <= word_in.rem;
			mon_s3  <= mon_prod[25:19];
			q100_s3 <= q100_prod[34:24];
		end
	end

	// stage 4: day digits and gregorian leap rule
	always_comb begin
		mon100   = 14'(mon_s3) * 14'd100;
		day_full = rem_s3 - mon100;
		q100x100 = 18'(q100_s3) * 18'd100;
		div100   = (year_s3 == q100x100);
		leap_c   = (year_s3[1:0] == 2'd0 && !div100) || (div100 && q100_s3[1:0] == 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4 <= mode_s3;
			year_s4 <= year_s3;
			rem_s4  <= rem_s3;
			mon_s4  <= mon_s3;
			day_s4  <= day_full[6:0];
			leap_s4 <= leap_c;
		end
	end

	// stage 4 word to the next unit
	assign word_out = {valid_s4, mode_s4, year_s4, rem_s4, mon_s4, day_s4, leap_s4};

endmodule

// ===== src/cdoc_assemble.sv =====
// stages 5-6: range checks, month search and packing of the result
module cdoc_assemble (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  cdoc_pkg::fld_word_t   word_in,
	output logic                  out_valid,
	output logic [26:0]           converted_date,
	output logic                  valid_res
);

	logic        valid_s5;
	logic        mode_s5;
	logic        ok_s5;
	logic [13:0] year_s5;
	logic [3:0]  mon_s5;
	logic [9:0]  ofs_s5;

	logic [9:0]  yday;
	logic [4:0]  mlen;
	logic [8:0]  start_cal;
	logic [3:0]  mon_ord;
	logic [8:0]  start_ord;
	logic [9:0]  ylen;
	logic        ok_cal;
	logic        ok_ord;
	logic        ok_c;
	logic [3:0]  mon_c;
	logic [9:0]  ofs_c;
	logic [31:0] res_cal;
	logic [31:0] res_ord;
	logic [26:0] res_c;

	// stage 5: validate and locate the month
	always_comb begin
		yday = word_in.rem[9:0];
		mlen = cdoc_pkg::month_len(word_in.mon[3:0], word_in.leap);
		start_cal = cdoc_pkg::days_before(word_in.mon[3:0], word_in.leap);
		ok_cal = (word_in.mon >= 7'd1) && (word_in.mon <= 7'd12)
			&& (word_in.day >= 7'd1) && (word_in.day <= 7'(mlen));

		// last month whose start lies before the day of year
		mon_ord = 4'd1;
		for (int m = 2; m <= 12; m++) begin
			if (yday > 10'(cdoc_pkg::days_before(4'(m), word_in.leap))) begin
				mon_ord = 4'(m);
			end
		end
		start_ord = cdoc_pkg::days_before(mon_ord, word_in.leap);
		ylen = word_in.leap ? 10'd366 : 10'd365;
		ok_ord = (word_in.year <= 18'(cdoc_pkg::MAX_CAL_YEAR))
			&& (yday >= 10'd1) && (yday <= ylen);

		if (word_in.mode == cdoc_pkg::MODE_CAL_TO_ORD) begin
			ok_c  = ok_cal;
			mon_c = word_in.mon[3:0];
			ofs_c = 10'(start_cal) + 10'(word_in.day);
		end else begin
			ok_c  = ok_ord;
			mon_c = mon_ord;
			ofs_c = yday - 10'(start_ord);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5 <= word_in.mode;
			ok_s5   <= ok_c;
			year_s5 <= word_in.year[13:0];
			mon_s5  <= mon_c;
			ofs_s5  <= ofs_c;
		end
	end

	// stage 6: decimal packing, zero when invalid
	always_comb begin
		res_cal = 32'(year_s5) * 32'd1000 + 32'(ofs_s5);
		res_ord = 32'(year_s5) * 32'd10000 + 32'(mon_s5) * 32'd100 + 32'(ofs_s5);
		if (!ok_s5) begin
			res_c = 27'd0;
		end else if (mode_s5 == cdoc_pkg::MODE_CAL_TO_ORD) begin
			res_c = res_cal[26:0];
		end else begin
			res_c = res_ord[26:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			converted_date <= res_c;
			valid_res      <= ok_s5;
		end
	end

endmodule

// ===== src/calendar_date_ordinal_convert.sv =====
// Gregorian calendar/ordinal date converter, six-stage pipeline. A word of
// mode and packed date is taken at any edge where in_ready is high and its
// result reaches the outputs through six register stages; one word per
// cycle is sustained while the output is not stalled. The whole pipe
// advances together whenever the output register is empty or being taken, so
// a stall at the output holds every stage in place. The stages hold the
// divide-by-10000/1000 reciprocal multiply and its correction, the divide by
// 100 for month and century, the table checks and the final packing multiply.
module calendar_date_ordinal_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [26:0] date_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [26:0] converted_date,
	output logic        valid_res
);

	cdoc_pkg::div_word_t div_word;
	cdoc_pkg::fld_word_t fld_word;
	logic                en;

	// pipe advances when the output slot is free
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	cdoc_divide u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.mode       (mode),
		.date_value (date_value),
		.word_out   (div_word)
	);

	cdoc_field u_field (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.word_in  (div_word),
		.word_out (fld_word)
	);

	cdoc_assemble u_assemble (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.word_in        (fld_word),
		.out_valid      (out_valid),
		.converted_date (converted_date),
		.valid_res      (valid_res)
	);

endmodule
